### sv/animation_time_sensor_macros.svh
// Assertion macros shared by the time sensor RTL.
`ifndef ANIMATION_TIME_SENSOR_MACROS_SVH
`define ANIMATION_TIME_SENSOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ATS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ats_pkg.sv
// Shared types and constants of the animation time sensor.
`timescale 1ns / 1ps

package ats_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int PHASE_FRAC_DEF = 16;
  localparam int TIME_FRAC_BITS = 16;   // fraction bits of the time format

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_START_TIME     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_TIME      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CYCLE_INTERVAL = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_MODE      = 2'd3;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_NUMER,
    ST_RUN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic over;     // quotient is 2.0 or more, or divisor is zero
    logic rem_nz;   // non-zero remainder after the last fraction bit
  } div_flags_t;

endpackage

### sv/ats_div.sv
// Restoring divider, one quotient bit per cycle: integer bit then fraction bits.
`timescale 1ns / 1ps

module ats_div #(
  parameter int TIME_BITS       = ats_pkg::TIME_BITS_DEF,
  parameter int PHASE_FRAC_BITS = ats_pkg::PHASE_FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [TIME_BITS-1:0]     num_mag,
  input  logic [TIME_BITS-1:0]     den,
  output logic                     busy,
  output logic [PHASE_FRAC_BITS:0] quot,
  output ats_pkg::div_flags_t      flags
);

  localparam int STEPS = PHASE_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEPS);

  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] den_r;
  logic [CNT_W-1:0]     cnt;
  logic                 first;
  logic                 over;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 take;

  // first step compares without a shift: that bit is the integer part
  assign trial = first ? {1'b0, rem} : {rem, 1'b0};
  assign take  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      first <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      first <= 1'b1;
    end else if (busy) begin
      first <= 1'b0;
      cnt   <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num_mag;
      den_r <= den;
      quot  <= '0;
      over  <= {1'b0, num_mag} >= {den, 1'b0};
    end else if (busy) begin
      quot <= {quot[PHASE_FRAC_BITS-1:0], take};
      if (take) begin
        rem <= diff[TIME_BITS-1:0];
      end else begin
        rem <= trial[TIME_BITS-1:0];
      end
    end
  end

  assign flags.over   = over;
  assign flags.rem_nz = rem != '0;

endmodule

### sv/ats_mul.sv
// Shift-and-add multiplier: interval times phase magnitude, one multiplier bit per cycle.
`timescale 1ns / 1ps

module ats_mul #(
  parameter int TIME_BITS       = ats_pkg::TIME_BITS_DEF,
  parameter int PHASE_FRAC_BITS = ats_pkg::PHASE_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [TIME_BITS-1:0]       mcand,
  input  logic [PHASE_FRAC_BITS+1:0] mplier,
  output logic                       busy,
  output logic [TIME_BITS+1:0]       prod    // (mcand * mplier) >> PHASE_FRAC_BITS
);

  localparam int N     = PHASE_FRAC_BITS + 2;
  localparam int CNT_W = $clog2(N);

  logic [TIME_BITS-1:0] hi;
  logic [N-1:0]         lo;
  logic [N-1:0]         pm;
  logic [TIME_BITS-1:0] mc;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS:0]   sum;

  assign sum = {1'b0, hi} + (pm[0] ? {1'b0, mc} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // partial sum shifts right; dropped low bits collect in lo
  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= '0;
      pm <= mplier;
      mc <= mcand;
    end else if (busy) begin
      hi <= sum[TIME_BITS:1];
      lo <= {sum[0], lo[N-1:1]};
      pm <= {1'b0, pm[N-1:1]};
    end
  end

  assign prod = {hi, lo[N-1:PHASE_FRAC_BITS]};

endmodule

### sv/animation_time_sensor.sv
// Top level of the animation time sensor: sequencer, sensor state and stream ports.
//
//   channel  dir  handshake          payload
//   cfg      in   cfg_we             cfg_addr, cfg_data
//   s        in   s_tvalid/s_tready  s_tdata, s_tuser
//   m        out  m_tvalid/m_tready  m_tdata
//
// A tick passes through the setup and numerator states, the bit-serial multiplier
// and divider (the divider finishes first), a state that waits for both units to
// be idle, and the update. An enable write goes straight from accept to the update.
// One item is in flight; the next is taken once the result sits in the output
// register, and a stalled output holds the update. Reset is synchronous, no
// clearing pass.
`timescale 1ns / 1ps
`include "animation_time_sensor_macros.svh"

module animation_time_sensor #(
  parameter int TIME_BITS       = ats_pkg::TIME_BITS_DEF,
  parameter int PHASE_FRAC_BITS = ats_pkg::PHASE_FRAC_DEF,
  localparam int IN_W  = ((TIME_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_W = ((PHASE_FRAC_BITS + 2 + 2 + TIME_BITS + 1 + TIME_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ats_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TIME_BITS-1:0]          cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,   // time_now, enable_value
  input  logic                          s_tuser,   // kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata    // phase, active, enabled, cycle_origin, event_time
);

  localparam int F   = PHASE_FRAC_BITS;
  localparam int TB  = TIME_BITS;
  localparam int PW  = F + 2;
  localparam int OW  = TB + 1;
  localparam int NW  = TB + 3;

  localparam logic signed [PW-1:0] P_ONE = PW'(64'd1 << F);
  localparam logic signed [PW-1:0] P_MAX = PW'((64'd1 << (F + 1)) - 64'd1);
  localparam logic signed [PW-1:0] P_MIN = PW'(64'd1 << (F + 1));
  localparam logic [F:0]           MQ_ONE = (F+1)'(64'd1 << F);
  localparam logic [OW-1:0]        O_MAX = {1'b0, {TB{1'b1}}};
  localparam logic [OW-1:0]        O_MIN = {1'b1, {TB{1'b0}}};

  // configuration
  logic [TB-1:0] start_time;
  logic [TB-1:0] stop_time;
  logic [TB-1:0] cycle_interval;
  logic          loop_mode;

  // sensor state
  logic                 enabled_bit;
  logic                 active_bit;
  logic signed [OW-1:0] origin_reg;
  logic signed [PW-1:0] phase_reg;
  logic [TB-1:0]        event_reg;

  logic                 enabled_next;
  logic                 active_next;
  logic signed [OW-1:0] origin_next;
  logic signed [PW-1:0] phase_next;
  logic [TB-1:0]        event_next;

  // current item and setup results
  logic          item_kind;
  logic [TB-1:0] item_time;
  logic          item_en;
  logic          range_r;
  logic          cyc_r;
  logic [TB-1:0] base_r;
  logic [TB-1:0] den_r;
  logic          num_neg;
  logic          num_zero;

  ats_pkg::state_t state;
  ats_pkg::state_t state_next;
  logic            unit_start;
  logic            upd_fire;

  logic                range_c;
  logic                cyc_c;
  logic                t_ge_base;
  logic [TB-1:0]       num_mag_c;
  logic [PW-1:0]       p_abs;

  logic                div_busy;
  logic [F:0]          mq;
  ats_pkg::div_flags_t dflags;
  logic                mul_busy;
  logic [TB+1:0]       prod;

  logic signed [PW-1:0] q_c;
  logic                 before_c;
  logic                 after_c;
  logic signed [PW-1:0] q_plus;
  logic signed [PW-1:0] q_minus;
  logic signed [OW-1:0] o_minus;
  logic signed [OW:0]   o_plus_w;
  logic signed [OW-1:0] o_plus;
  logic signed [NW-1:0] no_w;
  logic signed [OW-1:0] no_sat;
  logic                 no_gt_one;
  logic                 t_ge_stop;
  logic                 t_ge_start;

  function automatic logic signed [PW-1:0] sat_ph(input logic signed [PW:0] x);
    logic signed [PW-1:0] r;
    if (x > (PW+1)'(P_MAX)) begin
      r = P_MAX;
    end else if (x < (PW+1)'(P_MIN)) begin
      r = P_MIN;
    end else begin
      r = x[PW-1:0];
    end
    return r;
  endfunction

  // ---------------- configuration writes ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time     <= '0;
      stop_time      <= '0;
      cycle_interval <= TB'(64'd1 << ats_pkg::TIME_FRAC_BITS);
      loop_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ats_pkg::REG_START_TIME:     start_time     <= cfg_data;
        ats_pkg::REG_STOP_TIME:      stop_time      <= cfg_data;
        ats_pkg::REG_CYCLE_INTERVAL: cycle_interval <= cfg_data;
        ats_pkg::REG_LOOP_MODE:      loop_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ats_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unit_start = 1'b0;
    upd_fire   = 1'b0;
    unique case (state)
      ats_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (s_tuser == ats_pkg::KIND_ENABLE) ? ats_pkg::ST_UPDATE
                                                         : ats_pkg::ST_SETUP;
        end
      end
      ats_pkg::ST_SETUP: begin
        state_next = ats_pkg::ST_NUMER;
      end
      ats_pkg::ST_NUMER: begin
        unit_start = 1'b1;
        state_next = ats_pkg::ST_RUN;
      end
      ats_pkg::ST_RUN: begin
        if (!div_busy && !mul_busy) begin
          state_next = ats_pkg::ST_UPDATE;
        end
      end
      ats_pkg::ST_UPDATE: begin
        if (!m_tvalid || m_tready) begin
          upd_fire   = 1'b1;
          state_next = ats_pkg::ST_IDLE;
        end
      end
      default: state_next = ats_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_kind <= s_tuser;
      item_time <= s_tdata[TB-1:0];
      item_en   <= s_tdata[TB];
    end
  end

  // ---------------- setup: mode, base and divisor, then numerator ----------------
  assign range_c = start_time < stop_time;
  // a positive stored origin takes over from the start time outside range mode
  assign cyc_c   = !range_c && !origin_reg[OW-1] && (origin_reg != '0);

  always_ff @(posedge clk) begin
    if (state == ats_pkg::ST_SETUP) begin
      range_r <= range_c;
      cyc_r   <= cyc_c;
      base_r  <= cyc_c ? origin_reg[TB-1:0] : start_time;
      den_r   <= range_c ? (stop_time - start_time) : cycle_interval;
    end
  end

  assign t_ge_base = item_time >= base_r;
  assign num_mag_c = t_ge_base ? (item_time - base_r) : (base_r - item_time);
  assign p_abs     = phase_reg[PW-1] ? PW'(-phase_reg) : phase_reg;

  always_ff @(posedge clk) begin
    if (state == ats_pkg::ST_NUMER) begin
      num_neg  <= !t_ge_base;
      num_zero <= item_time == base_r;
    end
  end

  ats_div #(
    .TIME_BITS       (TIME_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .num_mag (num_mag_c),
    .den     (den_r),
    .busy    (div_busy),
    .quot    (mq),
    .flags   (dflags)
  );

  // |phase| * interval, needed when an idle cycle sensor restarts
  ats_mul #(
    .TIME_BITS       (TIME_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .mcand  (cycle_interval),
    .mplier (p_abs),
    .busy   (mul_busy),
    .prod   (prod)
  );

  // ---------------- quotient to phase and class ----------------
  always_comb begin
    if (num_zero) begin
      q_c = '0;
    end else if (dflags.over) begin
      q_c = num_neg ? P_MIN : P_MAX;
    end else if (num_neg) begin
      q_c = -({1'b0, mq} + PW'(dflags.rem_nz));
    end else begin
      q_c = {1'b0, mq};
    end
  end

  assign before_c = !num_zero && num_neg;
  assign after_c  = !num_zero && !num_neg &&
                    (dflags.over || (mq > MQ_ONE) || ((mq == MQ_ONE) && dflags.rem_nz));

  assign q_plus  = sat_ph((PW+1)'(q_c) + (PW+1)'(P_ONE));
  assign q_minus = sat_ph((PW+1)'(q_c) - (PW+1)'(P_ONE));

  // origin moves: back one interval cannot leave range, forward may clip high
  assign o_minus  = origin_reg - $signed({1'b0, cycle_interval});
  assign o_plus_w = (OW+1)'(origin_reg) + $signed({2'b00, cycle_interval});
  assign o_plus   = (!o_plus_w[OW] && o_plus_w[OW-1]) ? O_MAX : o_plus_w[OW-1:0];

  // restart origin: time minus phase * interval, clipped to the origin range
  assign no_w = phase_reg[PW-1] ? ($signed(NW'(item_time)) + $signed(NW'(prod)))
                                : ($signed(NW'(item_time)) - $signed(NW'(prod)));

  always_comb begin
    if (!no_w[NW-1] && (no_w[NW-2:TB] != '0)) begin
      no_sat = O_MAX;
    end else if (no_w[NW-1] && !(&no_w[NW-2:TB])) begin
      no_sat = O_MIN;
    end else begin
      no_sat = no_w[OW-1:0];
    end
  end

  assign no_gt_one  = !no_w[NW-1] && (no_w[NW-2:1] != '0);
  assign t_ge_stop  = item_time >= stop_time;
  assign t_ge_start = item_time >= start_time;

  // ---------------- sensor update ----------------
  always_comb begin
    enabled_next = enabled_bit;
    active_next  = active_bit;
    origin_next  = origin_reg;
    phase_next   = phase_reg;
    event_next   = event_reg;
    if (item_kind == ats_pkg::KIND_ENABLE) begin
      enabled_next = item_en;
    end else if (!enabled_bit) begin
      if (active_bit) begin
        event_next  = item_time;
        active_next = 1'b0;
        phase_next  = q_c;
      end
    end else if (before_c) begin
      if (cyc_r && active_bit) begin
        event_next = item_time;
        if (!loop_mode) begin
          active_next = 1'b0;
          phase_next  = P_ONE;
          origin_next = {1'b0, item_time};
        end else begin
          origin_next = o_minus;
          phase_next  = q_plus;
        end
      end
    end else if (after_c) begin
      if (active_bit) begin
        if (!loop_mode) begin
          // one-shot end shuts the sensor down
          active_next  = 1'b0;
          event_next   = '0;
          phase_next   = P_ONE;
          origin_next  = '0;
          enabled_next = 1'b0;
        end else begin
          origin_next = o_plus;
          event_next  = item_time;
          phase_next  = q_minus;
        end
      end else if (!range_r) begin
        phase_next  = '0;
        origin_next = {1'b0, item_time};
        active_next = 1'b1;
        event_next  = item_time;
      end
    end else if (!active_bit) begin
      event_next = item_time;
      if (range_r) begin
        origin_next = {1'b0, start_time};
        active_next = 1'b1;
        phase_next  = q_c;
      end else begin
        origin_next = no_sat;
        if (no_gt_one) begin
          active_next = 1'b1;
        end
      end
    end else if (range_r && t_ge_stop) begin
      active_next = 1'b0;
    end else if (t_ge_start) begin
      event_next = item_time;
      phase_next = q_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_bit <= 1'b1;
      active_bit  <= 1'b0;
      origin_reg  <= '0;
      phase_reg   <= '0;
      event_reg   <= '0;
    end else if (upd_fire) begin
      enabled_bit <= enabled_next;
      active_bit  <= active_next;
      origin_reg  <= origin_next;
      phase_reg   <= phase_next;
      event_reg   <= event_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      m_tdata <= OUT_W'({event_next, origin_next, enabled_next, active_next, phase_next});
    end
  end

  // ---------------- checks ----------------
  `ATS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
                   "new beat taken while an item is in flight")
  `ATS_ASSERT_NOW(a_units_in_run, div_busy || mul_busy, state == ats_pkg::ST_RUN,
                  "arithmetic units busy outside the run state")
  `ATS_ASSERT_NOW(a_active_needs_enable, $rose(active_bit), enabled_bit,
                  "sensor became active while disabled")

endmodule
